// ===== src/ubsc_pkg.sv =====
package ubsc_pkg;

	// Default width of the remaining-bit counter.
	localparam int LEN_WIDTH_DEF = 16;

	// Output queue geometry.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// Push counts handed from the aligner to the output queue.
	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_ONE  = 2'd1;
	localparam logic [1:0] PUSH_TWO  = 2'd2;

	localparam logic [7:0] BYTE_ALL = 8'hFF;

	// One accepted input transaction.
	typedef struct packed {
		logic [7:0]  src_byte;
		logic        start_req;
		logic [2:0]  src_bit_offset;
		logic [2:0]  dst_bit_offset;
		logic [15:0] bit_length;
	} item_t;

	// One destination byte with its bit-write mask.
	typedef struct packed {
		logic [7:0] dst_byte;
		logic [7:0] write_mask;
		logic       last;
	} result_t;

	// Mask of cnt bits starting at bit position start, MSB first.
	function automatic logic [7:0] byte_mask(input logic [2:0] start, input logic [3:0] cnt);
		logic [3:0] stop;
		stop = {1'b0, start} + cnt;
		return (BYTE_ALL >> start) & ~(BYTE_ALL >> stop);
	endfunction

endpackage

// ===== src/unaligned_bit_stream_copy_core.sv =====
// Unaligned bit-stream copy, MSB first. A start transaction latches the source and
// destination bit offsets and the bit length; each following source transaction
// delivers one byte, beginning with the byte that holds the first copied bit, and
// yields up to one destination byte with a write mask (two on the final source byte
// when the last owed bits fit into it). One source byte is taken every cycle while the
// output queue has room; each byte is held in the input register, then the realigner
// writes its results into a four-entry output queue. Input ready drops only while the
// output queue holds more than two entries, i.e. when the result side stalls. A zero
// length or a start transaction gives no results; a start during a copy abandons it.
module unaligned_bit_stream_copy_core #(
	parameter int LEN_WIDTH = ubsc_pkg::LEN_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_byte,
	input  logic        start_req,
	input  logic [2:0]  src_bit_offset,
	input  logic [2:0]  dst_bit_offset,
	input  logic [15:0] bit_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  dst_byte,
	output logic [7:0]  write_mask,
	output logic        last
);
	import ubsc_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	logic       room;
	logic       advance;
	logic [1:0] push_cnt;
	result_t    res_a;
	result_t    res_b;
	result_t    out_res;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.src_byte       <= src_byte;
			item_s1.start_req      <= start_req;
			item_s1.src_bit_offset <= src_bit_offset;
			item_s1.dst_bit_offset <= dst_bit_offset;
			item_s1.bit_length     <= bit_length;
		end
	end

	// Realigner and copy state.
	ubsc_align #(
		.LEN_WIDTH (LEN_WIDTH)
	) u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.push_cnt (push_cnt),
		.res_a    (res_a),
		.res_b    (res_b)
	);

	// Output queue.
	ubsc_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_a    (res_a),
		.push_b    (res_b),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign dst_byte   = out_res.dst_byte;
	assign write_mask = out_res.write_mask;
	assign last       = out_res.last;

endmodule

// ===== src/ubsc_align.sv =====
module ubsc_align #(
	parameter int LEN_WIDTH = ubsc_pkg::LEN_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ubsc_pkg::item_t   item,
	output logic [1:0]        push_cnt,
	output ubsc_pkg::result_t res_a,
	output ubsc_pkg::result_t res_b
);
	import ubsc_pkg::*;

	localparam int CW = LEN_WIDTH + 1;

	logic [7:0]           held_q;
	logic [LEN_WIDTH-1:0] rem_q;
	logic [2:0]           shamt_q;
	logic                 sl_q;
	logic [2:0]           off_q;
	logic                 active_q;
	logic                 pend_q;

	logic [15:0]          funnel0;
	logic [15:0]          funnel1;
	logic [7:0]           v0;
	logic [7:0]           v2;
	logic [2:0]           start1;
	logic [3:0]           avail1;
	logic [LEN_WIDTH-1:0] cnt1_w;
	logic [7:0]           mask1;
	logic [7:0]           mask2;
	logic                 e1;
	logic                 e2;
	logic [LEN_WIDTH-1:0] rem1;
	logic                 pend1;
	logic                 act1;
	logic [2:0]           start2;
	logic [CW-1:0]        sum2;
	logic                 data_fire;
	result_t              r1;
	result_t              r2;

	// Funnel shift of the held byte and the current byte into a destination slot.
	always_comb begin
		funnel0 = {held_q, item.src_byte} >> shamt_q;
		funnel1 = {item.src_byte, 8'h00} >> shamt_q;
		v0      = funnel0[7:0];
		v2      = funnel1[7:0];
	end

	// First slot: dropped when it holds no copy bits, otherwise masked and counted.
	always_comb begin
		e1     = !sl_q;
		start1 = pend_q ? off_q : 3'd0;
		avail1 = 4'd8 - {1'b0, start1};
		cnt1_w = (rem_q < LEN_WIDTH'(avail1)) ? rem_q : LEN_WIDTH'(avail1);
		mask1  = byte_mask(start1, cnt1_w[3:0]);
		if (e1) begin
			rem1  = rem_q - cnt1_w;
			pend1 = 1'b0;
		end else begin
			rem1  = rem_q;
			pend1 = pend_q;
		end
		act1 = (rem1 != '0);
	end

	// Second slot: the bits still owed all lie in the current byte.
	always_comb begin
		start2 = pend1 ? off_q : 3'd0;
		sum2   = CW'(rem1) + CW'(start2);
		e2     = act1 && (sum2 <= CW'(shamt_q));
		mask2  = byte_mask(start2, rem1[3:0]);
	end

	always_comb begin
		r1.dst_byte   = v0 & mask1;
		r1.write_mask = mask1;
		r1.last       = !act1;
		r2.dst_byte   = v2 & mask2;
		r2.write_mask = mask2;
		r2.last       = 1'b1;
	end

	// Pack the emitted results for the output queue.
	assign data_fire = fire && !item.start_req && active_q;

	always_comb begin
		res_a = e1 ? r1 : r2;
		res_b = r2;
		if (!data_fire) begin
			push_cnt = PUSH_NONE;
		end else if (e1 && e2) begin
			push_cnt = PUSH_TWO;
		end else if (e1 || e2) begin
			push_cnt = PUSH_ONE;
		end else begin
			push_cnt = PUSH_NONE;
		end
	end

	// Copy state: latched by a start transaction, advanced by each source byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 8'h00;
			rem_q    <= '0;
			shamt_q  <= 3'd0;
			sl_q     <= 1'b0;
			off_q    <= 3'd0;
			active_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (fire && item.start_req) begin
			held_q   <= 8'h00;
			rem_q    <= LEN_WIDTH'(item.bit_length);
			shamt_q  <= item.dst_bit_offset - item.src_bit_offset;
			sl_q     <= item.src_bit_offset > item.dst_bit_offset;
			off_q    <= item.dst_bit_offset;
			active_q <= (LEN_WIDTH'(item.bit_length) != '0);
			pend_q   <= 1'b1;
		end else if (data_fire) begin
			held_q   <= item.src_byte;
			sl_q     <= 1'b0;
			rem_q    <= e2 ? '0 : rem1;
			active_q <= e2 ? 1'b0 : act1;
			pend_q   <= e2 ? 1'b0 : pend1;
		end
	end

`ifndef ASSERT_OFF
	a_active_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q == (rem_q != '0))
		else $error("copy activity disagrees with the remaining-bit count");

	a_two_ends_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == PUSH_TWO) |-> (res_b.last && !res_a.last))
		else $error("a double push must end the copy on its second result");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == PUSH_TWO) |=> !active_q)
		else $error("copy still active after its final byte");

	a_mask_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != PUSH_NONE) |->
			(res_a.write_mask != 8'h00 && (res_a.dst_byte & ~res_a.write_mask) == 8'h00))
		else $error("result byte with empty mask or bits outside its mask");
`endif

endmodule

// ===== src/ubsc_oq.sv =====
module ubsc_oq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  ubsc_pkg::result_t push_a,
	input  ubsc_pkg::result_t push_b,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output ubsc_pkg::result_t out_res
);
	import ubsc_pkg::*;

	result_t            mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]   wp_q;
	logic [OQ_AW-1:0]   rp_q;
	logic [OQ_AW:0]     cnt_q;
	logic [OQ_AW-1:0]   wp_next;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign wp_next   = wp_q + OQ_AW'(1);

	// Room for a full double push, regardless of a pop this cycle.
	assign room = (cnt_q <= (OQ_AW + 1)'(OQ_DEPTH - 2));

	// Entry storage: up to two writes per cycle at consecutive slots.
	always_ff @(posedge clk) begin
		if (push_cnt != PUSH_NONE) begin
			mem_q[wp_q] <= push_a;
		end
		if (push_cnt == PUSH_TWO) begin
			mem_q[wp_next] <= push_b;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OQ_AW'(push_cnt);
			if (pop) begin
				rp_q <= rp_q + OQ_AW'(1);
			end
			cnt_q <= cnt_q + (OQ_AW + 1)'(push_cnt) - (OQ_AW + 1)'(pop);
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ubsc_pkg::*;

	localparam int LEN_W        = LEN_WIDTH_DEF;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_PRINTS   = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  src_byte = '0;
	logic        start_req = 1'b0;
	logic [2:0]  src_bit_offset = '0;
	logic [2:0]  dst_bit_offset = '0;
	logic [15:0] bit_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  dst_byte;
	logic [7:0]  write_mask;
	logic        last;

	int in_idle_pct  = 0;
	int out_idle_pct = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	// Destination bytes predicted but not yet seen on the result channel.
	result_t pending_dst_bytes[$];

	// Predictor state for the realigner.
	logic [7:0]       held_src = '0;
	logic [LEN_W-1:0] bits_owed = '0;
	logic [2:0]       funnel_shift = '0;
	logic             skip_lead_slot = 1'b0;
	logic [2:0]       dst_first_offset = '0;
	logic             copy_busy = 1'b0;
	logic             first_dst_pending = 1'b0;

	unaligned_bit_stream_copy_core #(.LEN_WIDTH(LEN_W)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.src_byte       (src_byte),
		.start_req      (start_req),
		.src_bit_offset (src_bit_offset),
		.dst_bit_offset (dst_bit_offset),
		.bit_length     (bit_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.dst_byte       (dst_byte),
		.write_mask     (write_mask),
		.last           (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Masks one funnel slot to the destination bits it covers and queues the byte.
	// The slot ahead of the first copied bit is dropped when the source leads.
	function automatic void queue_dst_slot(input logic [7:0] slot);
		int unsigned first_bit;
		int unsigned nbits;
		logic [7:0]  mask;
		result_t     r;
		if (skip_lead_slot) begin
			skip_lead_slot = 1'b0;
			return;
		end
		first_bit = first_dst_pending ? dst_first_offset : 0;
		nbits = (bits_owed < 8 - first_bit) ? bits_owed : 8 - first_bit;
		mask = 8'((32'hFF >> first_bit) & ~(32'hFF >> (first_bit + nbits)));
		bits_owed = bits_owed - LEN_W'(nbits);
		first_dst_pending = 1'b0;
		r.dst_byte = slot & mask;
		r.write_mask = mask;
		r.last = (bits_owed == 0);
		if (bits_owed == 0) begin
			copy_busy = 1'b0;
		end
		pending_dst_bytes.push_back(r);
	endfunction

	// Advances the predictor by one accepted input transaction.
	function automatic void realign_source_byte(input logic [7:0] b, input logic st,
			input logic [2:0] so, input logic [2:0] dof, input logic [15:0] len);
		logic [15:0] funnel;
		int unsigned first_bit;
		if (st) begin
			skip_lead_slot = (so > dof);
			funnel_shift = (so > dof) ? 3'(8 - (so - dof)) : 3'(dof - so);
			dst_first_offset = dof;
			first_dst_pending = 1'b1;
			held_src = '0;
			bits_owed = len[LEN_W-1:0];
			copy_busy = (len[LEN_W-1:0] != 0);
			return;
		end
		if (!copy_busy) begin
			return;
		end
		funnel = {held_src, b} >> funnel_shift;
		queue_dst_slot(funnel[7:0]);
		held_src = b;
		// When the owed bits all lie in this byte, the tail goes out at once.
		if (copy_busy && !skip_lead_slot) begin
			first_bit = first_dst_pending ? dst_first_offset : 0;
			if (bits_owed != 0 && first_bit + bits_owed <= funnel_shift) begin
				funnel = {held_src, 8'h00} >> funnel_shift;
				queue_dst_slot(funnel[7:0]);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("ERROR at %0t: %s, got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	// Sends one transaction, called just after a falling edge; returns after the
	// falling edge that follows its acceptance, with valid still high.
	task automatic send_item(input logic [7:0] b, input logic st, input logic [2:0] so,
			input logic [2:0] dof, input logic [15:0] len);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		src_byte       <= b;
		start_req      <= st;
		src_bit_offset <= so;
		dst_bit_offset <= dof;
		bit_length     <= len;
		do begin
			@(posedge clk);
		end while (!in_ready);
		realign_source_byte(b, st, so, dof, len);
		@(negedge clk);
	endtask

	task automatic send_start(input logic [2:0] so, input logic [2:0] dof,
			input logic [15:0] len);
		send_item(8'($urandom), 1'b1, so, dof, len);
	endtask

	task automatic send_data(input logic [7:0] b);
		send_item(b, 1'b0, 3'($urandom), 3'($urandom), 16'($urandom));
	endtask

	// A source byte with no copy running, then a copy of zero length.
	task automatic test_idle_and_zero_length;
		send_data(8'h3C);
		send_start(3'd7, 3'd0, 16'd0);
		send_data(8'hFF);
	endtask

	// Equal offsets, and the extreme offsets on a single bit either way.
	task automatic test_edge_offsets;
		send_start(3'd0, 3'd0, 16'd8);
		send_data(8'hA5);
		send_start(3'd7, 3'd0, 16'd1);
		send_data(8'h01);
		send_start(3'd0, 3'd7, 16'd1);
		send_data(8'h80);
	endtask

	// The final owed bits fit in the current byte, so two bytes come out together.
	task automatic test_split_tail;
		send_start(3'd0, 3'd4, 16'd6);
		send_data(8'hC3);
		send_start(3'd3, 3'd5, 16'd10);
		send_data(8'h00);
		send_data(8'hFF);
	endtask

	// A maximum-length copy is abandoned by a new start part way through.
	task automatic test_abandon;
		send_start(3'd5, 3'd2, 16'hFFFF);
		send_data(8'hFF);
		send_data(8'h00);
		send_start(3'd2, 3'd5, 16'd3);
		send_data(8'hE7);
	endtask

	// Mostly complete copies with random content; some abandoned copies and
	// some stray source bytes between copies.
	task automatic test_random_copies(input int snd_idle, input int rcv_idle, input int target);
		int sent;
		int kind;
		int nbytes;
		logic [2:0]  so;
		logic [2:0]  dof;
		logic [15:0] len;
		in_idle_pct = snd_idle;
		out_idle_pct = rcv_idle;
		sent = 0;
		while (sent < target) begin
			kind = $urandom_range(99);
			so = 3'($urandom);
			dof = 3'($urandom);
			if (kind < 80) begin
				kind = $urandom_range(99);
				if (kind < 3) begin
					len = 16'd0;
				end else if (kind < 85) begin
					len = 16'($urandom_range(1, 48));
				end else if (kind < 97) begin
					len = 16'($urandom_range(49, 400));
				end else begin
					len = 16'($urandom_range(401, 1200));
				end
				nbytes = (len == 0) ? 0 : (int'(so) + int'(len) + 7) / 8;
				send_start(so, dof, len);
				repeat (nbytes) send_data(8'($urandom));
				sent += nbytes + 1;
			end else if (kind < 90) begin
				nbytes = $urandom_range(0, 4);
				send_start(so, dof, 16'($urandom));
				repeat (nbytes) send_data(8'($urandom));
				sent += nbytes + 1;
			end else begin
				// A trailing byte after a finished copy is ignored; after an abandoned copy it feeds that copy.
				send_data(8'($urandom));
			end
		end
	endtask

	// Result side: random back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= out_idle_pct);
	end

	// Compare each accepted result with the oldest predicted byte.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_dst_bytes.size() == 0) begin
				report_mismatch("result with nothing expected", dst_byte, 0);
			end else begin
				want = pending_dst_bytes.pop_front();
				if (dst_byte !== want.dst_byte) begin
					report_mismatch("dst_byte", dst_byte, want.dst_byte);
				end
				if (write_mask !== want.write_mask) begin
					report_mismatch("write_mask", write_mask, want.write_mask);
				end
				if (last !== want.last) begin
					report_mismatch("last", last, want.last);
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		in_idle_pct = 34;
		out_idle_pct = 77;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_and_zero_length();
		test_edge_offsets();
		test_split_tail();
		test_abandon();
		test_random_copies(34, 77, 250);
		test_random_copies(77, 34, 250);
		test_random_copies(0, 0, 250);
		in_valid <= 1'b0;

		// Drain the outstanding results, then allow for the pipeline latency.
		while (pending_dst_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_dst_bytes.size() != 0) begin
			report_mismatch("expected results never arrived", pending_dst_bytes.size(), 0);
		end
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
